/* src/plist_pkg.sv */
`default_nettype none

package plist_pkg;

  localparam int LIST_DEPTH_DEF = 64;
  localparam int SCAN_MAX = 8;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_FIND   = 2'd2,
    REQ_QUERY  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_SCAN,
    FS_HOLD
  } fsm_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_FIND,
    CELL_SCAN
  } cell_op_e;

  typedef struct packed {
    req_e               req_type;
    logic [6:0]         position;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] removed_value;
    logic [6:0]         found_position;
    logic [6:0]         list_length;
    logic               is_empty;
  } rsp_t;

  typedef struct packed {
    cell_op_e           op;
    logic [6:0]         pos;
    logic signed [31:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* src/plist_cell.sv */
`default_nettype none

module plist_cell #(
  parameter int LIST_DEPTH = 64,
  parameter int INDEX = 0
) (
  input  wire logic                                 clk,
  input  wire plist_pkg::cell_ctrl_t                ctrl,
  input  wire logic [$clog2(LIST_DEPTH+1)-1:0]      count,
  input  wire logic signed [31:0]                   left_data,
  input  wire logic signed [31:0]                   right_data,
  input  wire logic                                 hit_far,
  output logic signed [31:0]                        data,
  output logic                                      hit,
  output logic signed [31:0]                        pick
);
  import plist_pkg::*;

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
  localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;

  assign pos_ext = CMP_W'(ctrl.pos);
  assign cnt_ext = CMP_W'(count);

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      CELL_INSERT: begin
        if (IDX > pos_ext) begin
          data <= left_data;
        end else if (IDX == pos_ext) begin
          data <= ctrl.value;
        end
      end
      CELL_DELETE: begin
        if (IDX >= pos_ext) begin
          data <= right_data;
        end
      end
      CELL_FIND: begin
        hit <= (IDX < cnt_ext) && (data == ctrl.value);
      end
      CELL_SCAN: begin
        hit <= hit_far;
      end
      default: begin
      end
    endcase
  end

  assign pick = (ctrl.op == CELL_DELETE && IDX == pos_ext) ? data : 32'sd0;

endmodule

`default_nettype wire

/* src/positional_list_engine.sv */
// Channel | Direction | Payload | Handshake
// req     | in        | req_t   | req_valid, req_stall
// rsp     | out       | rsp_t   | rsp_valid, rsp_stall
//
// Insert, delete and query are applied to the cell row on acceptance and can follow each other
// in consecutive cycles while the output register can drain.
// A find compares all cells at once, then scans the hits SCAN_MAX positions per step until the
// first match; a find without a match ends after the first scan step.
// Reset clears the element count and the control state; element storage is not cleared.
// A stalled result is held in a spare register, and requests are stalled until it moves out.
`default_nettype none

module positional_list_engine #(
  parameter int LIST_DEPTH = plist_pkg::LIST_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire plist_pkg::req_t req,
  output logic                 rsp_valid,
  input  wire logic            rsp_stall,
  output plist_pkg::rsp_t      rsp
);
  import plist_pkg::*;

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
  localparam int SCAN_W = (LIST_DEPTH < SCAN_MAX) ? LIST_DEPTH : SCAN_MAX;
  localparam int PE_W = (SCAN_W > 1) ? $clog2(SCAN_W) : 1;

  fsm_e                state;
  fsm_e                state_next;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [CNT_W-1:0]    base;
  logic [CNT_W-1:0]    base_next;
  rsp_t                res;
  rsp_t                fin_data;
  logic                fin;
  logic                accept;
  logic                out_free;
  cell_ctrl_t          ctrl;
  logic signed [31:0]  cell_data [LIST_DEPTH];
  logic signed [31:0]  cell_pick [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] hit_vec;
  logic signed [31:0]  removed;
  logic [CMP_W-1:0]    pos_ext;
  logic [CMP_W-1:0]    cnt_ext;
  logic [SCAN_W-1:0]   low_hits;
  logic                rest_any;
  logic [PE_W-1:0]     pe;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic signed [31:0] left_d;
    logic signed [31:0] right_d;
    logic               far_hit;

    if (i == 0) begin : g_first
      assign left_d = cell_data[i];
    end else begin : g_left
      assign left_d = cell_data[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_right
      assign right_d = cell_data[i+1];
    end

    if (i + SCAN_W < LIST_DEPTH) begin : g_far
      assign far_hit = hit_vec[i+SCAN_W];
    end else begin : g_nofar
      assign far_hit = 1'b0;
    end

    plist_cell #(
      .LIST_DEPTH (LIST_DEPTH),
      .INDEX      (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count),
      .left_data  (left_d),
      .right_data (right_d),
      .hit_far    (far_hit),
      .data       (cell_data[i]),
      .hit        (hit_vec[i]),
      .pick       (cell_pick[i])
    );
  end

  assign accept   = req_valid && !req_stall;
  assign out_free = !rsp_valid || !rsp_stall;
  assign pos_ext  = CMP_W'(req.position);
  assign cnt_ext  = CMP_W'(count);
  assign low_hits = hit_vec[SCAN_W-1:0];
  assign rest_any = |(hit_vec >> SCAN_W);

  always_comb begin
    removed = 32'sd0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      removed = removed | cell_pick[i];
    end
  end

  always_comb begin
    pe = '0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (low_hits[i]) begin
        pe = PE_W'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    base_next  = base;
    req_stall  = rst || (state != FS_IDLE);
    fin        = 1'b0;
    ctrl.op    = CELL_HOLD;
    ctrl.pos   = req.position;
    ctrl.value = req.value;
    fin_data.status         = ST_OK;
    fin_data.removed_value  = 32'sd0;
    fin_data.found_position = 7'd0;
    fin_data.list_length    = 7'd0;
    fin_data.is_empty       = 1'b0;

    unique case (state)
      FS_IDLE: begin
        if (accept) begin
          unique case (req.req_type)
            REQ_INSERT: begin
              if (pos_ext > cnt_ext) begin
                fin_data.status = ST_RANGE;
              end else if (count == CNT_W'(LIST_DEPTH)) begin
                fin_data.status = ST_FULL;
              end else begin
                ctrl.op    = CELL_INSERT;
                count_next = count + CNT_W'(1);
              end
              fin = 1'b1;
            end
            REQ_DELETE: begin
              if (req.position == 7'd0 || pos_ext > cnt_ext) begin
                fin_data.status = ST_RANGE;
              end else begin
                ctrl.op    = CELL_DELETE;
                ctrl.pos   = req.position - 7'd1;
                count_next = count - CNT_W'(1);
                fin_data.removed_value = removed;
              end
              fin = 1'b1;
            end
            REQ_FIND: begin
              ctrl.op    = CELL_FIND;
              base_next  = '0;
              state_next = FS_SCAN;
            end
            REQ_QUERY: begin
              fin = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      FS_SCAN: begin
        ctrl.op = CELL_SCAN;
        if (low_hits != '0) begin
          fin = 1'b1;
          fin_data.found_position = 7'(base + CNT_W'(pe) + CNT_W'(1));
        end else if (!rest_any) begin
          fin = 1'b1;
          fin_data.status = ST_MISSING;
        end else begin
          base_next = base + CNT_W'(SCAN_W);
        end
        if (fin) begin
          state_next = FS_IDLE;
        end
      end
      FS_HOLD: begin
        if (out_free) begin
          state_next = FS_IDLE;
        end
      end
      default: begin
        state_next = FS_IDLE;
      end
    endcase

    fin_data.list_length = 7'(count_next);
    fin_data.is_empty    = (count_next == '0);
    if (fin && !out_free) begin
      state_next = FS_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FS_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if ((fin && out_free) || (state == FS_HOLD && out_free)) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    base <= base_next;
    if (fin && out_free) begin
      rsp <= fin_data;
    end else if (state == FS_HOLD && out_free) begin
      rsp <= res;
    end
    if (fin && !out_free) begin
      res <= fin_data;
    end
  end

endmodule

`default_nettype wire

/* src/plist_checker.sv */
`default_nettype none

module plist_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            req_valid,
  input wire logic            req_stall,
  input wire plist_pkg::req_t req,
  input wire logic            rsp_valid,
  input wire logic            rsp_stall,
  input wire plist_pkg::rsp_t rsp
);
  import plist_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("Stalled result changed before its transfer.");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.is_empty == (rsp.list_length == 7'd0))
    else $error("Empty flag disagrees with the list length.");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |->
      rsp.removed_value == 32'sd0 && rsp.found_position == 7'd0)
    else $error("Failed request reported a value or a position.");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("Result valid right after reset.");

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req))
    else $error("Stalled request changed before its transfer.");

endmodule

bind positional_list_engine plist_checker u_plist_checker (.*);

`default_nettype wire
